@@ src/time_of_day_arithmetic_core_defines.svh @@
// Assertion macros shared by the time-of-day arithmetic core.
`ifndef TIME_OF_DAY_ARITHMETIC_CORE_DEFINES_SVH
`define TIME_OF_DAY_ARITHMETIC_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// A condition that must hold at every clock edge outside reset.
`define TOD_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("time of day core: invariant failed");

// A condition that must hold whenever its trigger holds.
`define TOD_ASSERT_IMPLY(label, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("time of day core: implication failed");

`else

`define TOD_ASSERT_ALWAYS(label, cond)
`define TOD_ASSERT_IMPLY(label, pre, post)

`endif

`endif

@@ src/tod_pkg.sv @@
// Shared constants, operation codes and stage word types of the time-of-day core.
package tod_pkg;

  localparam logic [2:0] KIND_VALIDATE  = 3'd0;
  localparam logic [2:0] KIND_TO_SEC    = 3'd1;
  localparam logic [2:0] KIND_FROM_SEC  = 3'd2;
  localparam logic [2:0] KIND_COMPARE   = 3'd3;
  localparam logic [2:0] KIND_ADD       = 3'd4;
  localparam logic [2:0] KIND_SUB       = 3'd5;
  localparam logic [2:0] KIND_DURATION  = 3'd6;

  localparam logic [17:0] DAY_SEC      = 18'd86400;
  localparam logic [17:0] TWO_DAY_SEC  = 18'd172800;
  localparam logic [16:0] HOUR_SEC     = 17'd3600;
  localparam logic [11:0] MIN_SEC      = 12'd60;
  localparam logic [5:0]  MAX_HOUR     = 6'd23;
  localparam logic [5:0]  MAX_MINUTE   = 6'd59;
  localparam logic [5:0]  MAX_SECOND   = 6'd59;

  // Reciprocals for the constant divisions. The day divide works on n / 128
  // and may come out one low; hours and minutes are exact over their ranges.
  localparam logic [22:0] DAY_RECIP  = 23'((64'd1 << 32) / 675);
  localparam logic [12:0] HOUR_RECIP = 13'(((1 << 20) + 224) / 225);
  localparam logic [10:0] MIN_RECIP  = 11'(((1 << 14) + 14) / 15);

  typedef struct packed {
    logic [2:0]  kind;
    logic [5:0]  hour_a;
    logic [5:0]  minute_a;
    logic [5:0]  second_a;
    logic [4:0]  hour_b;
    logic [5:0]  minute_b;
    logic [5:0]  second_b;
    logic [31:0] seconds_in;
  } tod_in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        valid;
    logic [16:0] red_a;
    logic [16:0] red_b;
    logic [17:0] rem_n;
    logic        eq;
    logic        lt;
    logic        gt;
  } tod_red_t;

  typedef struct packed {
    logic [16:0] sec;
    logic        hms_en;
    logic        valid;
    logic        eq;
    logic        lt;
    logic        gt;
  } tod_time_t;

  typedef struct packed {
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [16:0] seconds;
    logic        is_valid;
    logic        eq;
    logic        lt;
    logic        gt;
  } tod_res_t;

endpackage

@@ src/tod_front.sv @@
// Front stages: seconds of both times, validity, comparison and day reduction of the count.
module tod_front import tod_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  tod_in_t  in_word,
  output logic     out_valid,
  input  logic     out_ready,
  output tod_red_t out_word
);

  typedef struct packed {
    logic [2:0]  kind;
    logic        valid;
    logic [17:0] raw_a;
    logic [16:0] raw_b;
    logic [15:0] quot;
    logic [17:0] n_low;
  } front_s1_t;

  logic      s1_v_r, s2_v_r;
  logic      ready1, ready2;
  front_s1_t s1_r, s1_nxt;
  tod_red_t  s2_r, s2_nxt;
  logic [47:0] day_prod;
  logic [32:0] quot_day;

  assign ready2   = !s2_v_r || out_ready;
  assign ready1   = !s1_v_r || ready2;
  assign in_ready = ready1;

  always_comb begin
    s1_nxt.kind  = in_word.kind;
    s1_nxt.valid = (in_word.hour_a <= MAX_HOUR) && (in_word.minute_a <= MAX_MINUTE) &&
                   (in_word.second_a <= MAX_SECOND);
    s1_nxt.raw_a = 18'(in_word.hour_a) * 18'(HOUR_SEC) +
                   18'(in_word.minute_a) * 18'(MIN_SEC) + 18'(in_word.second_a);
    s1_nxt.raw_b = 17'(in_word.hour_b) * HOUR_SEC +
                   17'(in_word.minute_b) * 17'(MIN_SEC) + 17'(in_word.second_b);
    day_prod     = 48'(in_word.seconds_in[31:7]) * 48'(DAY_RECIP);
    s1_nxt.quot  = day_prod[47:32];
    s1_nxt.n_low = in_word.seconds_in[17:0];
  end

  always_comb begin
    s2_nxt.kind  = s1_r.kind;
    s2_nxt.valid = s1_r.valid;
    if (s1_r.raw_a >= TWO_DAY_SEC) begin
      s2_nxt.red_a = 17'(s1_r.raw_a - TWO_DAY_SEC);
    end else if (s1_r.raw_a >= DAY_SEC) begin
      s2_nxt.red_a = 17'(s1_r.raw_a - DAY_SEC);
    end else begin
      s2_nxt.red_a = s1_r.raw_a[16:0];
    end
    if (18'(s1_r.raw_b) >= DAY_SEC) begin
      s2_nxt.red_b = 17'(18'(s1_r.raw_b) - DAY_SEC);
    end else begin
      s2_nxt.red_b = s1_r.raw_b;
    end
    // The true remainder is below two days, so 18 bits of the difference suffice.
    quot_day     = 33'(s1_r.quot) * 33'(DAY_SEC);
    s2_nxt.rem_n = s1_r.n_low - quot_day[17:0];
    s2_nxt.eq    = s1_r.raw_a == 18'(s1_r.raw_b);
    s2_nxt.lt    = s1_r.raw_a <  18'(s1_r.raw_b);
    s2_nxt.gt    = s1_r.raw_a >  18'(s1_r.raw_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      if (ready1) s1_v_r <= in_valid;
      if (ready2) s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1 && in_valid) s1_r <= s1_nxt;
    if (ready2 && s1_v_r) s2_r <= s2_nxt;
  end

  assign out_valid = s2_v_r;
  assign out_word  = s2_r;

endmodule

@@ src/tod_select.sv @@
// Middle stages: final day reduction of the count and the per-operation result time.
module tod_select import tod_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tod_red_t  in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output tod_time_t out_word
);

  typedef struct packed {
    logic [2:0]  kind;
    logic        valid;
    logic [16:0] red_a;
    logic [16:0] red_b;
    logic [16:0] n_mod;
    logic        eq;
    logic        lt;
    logic        gt;
  } select_s3_t;

  logic       s3_v_r, s4_v_r;
  logic       ready3, ready4;
  select_s3_t s3_r, s3_nxt;
  tod_time_t  s4_r, s4_nxt;
  logic [17:0] add_sum, sub_dif, dur_dif;
  logic [16:0] t_add, t_sub, t_dur;

  assign ready4   = !s4_v_r || out_ready;
  assign ready3   = !s3_v_r || ready4;
  assign in_ready = ready3;

  always_comb begin
    s3_nxt.kind  = in_word.kind;
    s3_nxt.valid = in_word.valid;
    s3_nxt.red_a = in_word.red_a;
    s3_nxt.red_b = in_word.red_b;
    s3_nxt.n_mod = (in_word.rem_n >= DAY_SEC) ? 17'(in_word.rem_n - DAY_SEC) :
                                                in_word.rem_n[16:0];
    s3_nxt.eq    = in_word.eq;
    s3_nxt.lt    = in_word.lt;
    s3_nxt.gt    = in_word.gt;
  end

  always_comb begin
    add_sum = {1'b0, s3_r.red_a} + {1'b0, s3_r.n_mod};
    t_add   = (add_sum >= DAY_SEC) ? 17'(add_sum - DAY_SEC) : add_sum[16:0];
    sub_dif = {1'b0, s3_r.red_a} - {1'b0, s3_r.n_mod};
    t_sub   = sub_dif[17] ? 17'(sub_dif + DAY_SEC) : sub_dif[16:0];
    dur_dif = {1'b0, s3_r.red_b} - {1'b0, s3_r.red_a};
    t_dur   = dur_dif[17] ? 17'(dur_dif + DAY_SEC) : dur_dif[16:0];

    s4_nxt.sec    = '0;
    s4_nxt.hms_en = 1'b0;
    s4_nxt.valid  = s3_r.valid;
    s4_nxt.eq     = 1'b0;
    s4_nxt.lt     = 1'b0;
    s4_nxt.gt     = 1'b0;
    unique case (s3_r.kind)
      KIND_TO_SEC:   s4_nxt.sec = s3_r.red_a;
      KIND_FROM_SEC: begin
        s4_nxt.sec    = s3_r.n_mod;
        s4_nxt.hms_en = 1'b1;
      end
      KIND_COMPARE: begin
        s4_nxt.eq = s3_r.eq;
        s4_nxt.lt = s3_r.lt;
        s4_nxt.gt = s3_r.gt;
      end
      KIND_ADD: begin
        s4_nxt.sec    = t_add;
        s4_nxt.hms_en = 1'b1;
      end
      KIND_SUB: begin
        s4_nxt.sec    = t_sub;
        s4_nxt.hms_en = 1'b1;
      end
      KIND_DURATION: s4_nxt.sec = t_dur;
      KIND_VALIDATE: s4_nxt.sec = '0;
      // The spare code gives a word of zeros throughout.
      default:       s4_nxt.valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      if (ready3) s3_v_r <= in_valid;
      if (ready4) s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready3 && in_valid) s3_r <= s3_nxt;
    if (ready4 && s3_v_r) s4_r <= s4_nxt;
  end

  assign out_valid = s4_v_r;
  assign out_word  = s4_r;

endmodule

@@ src/tod_split.sv @@
// Back stages: split of seconds since midnight into hours, minutes and seconds.
module tod_split import tod_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  tod_time_t in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output tod_res_t  out_word
);

  typedef struct packed {
    tod_time_t   base;
    logic [4:0]  hour;
    logic [11:0] rem;
    logic [5:0]  minute;
  } split_t;

  logic     s5_v_r, s6_v_r, s7_v_r, s8_v_r;
  logic     ready5, ready6, ready7, ready8;
  split_t   s5_r, s5_nxt, s6_r, s6_nxt, s7_r, s7_nxt;
  tod_res_t s8_r, s8_nxt;
  logic [25:0] hour_prod;
  logic [20:0] min_prod;
  logic [11:0] sec_left;

  assign ready8   = !s8_v_r || out_ready;
  assign ready7   = !s7_v_r || ready8;
  assign ready6   = !s6_v_r || ready7;
  assign ready5   = !s5_v_r || ready6;
  assign in_ready = ready5;

  // Hours: seconds / 3600 taken as (seconds / 16) / 225.
  always_comb begin
    hour_prod     = 26'(in_word.sec[16:4]) * 26'(HOUR_RECIP);
    s5_nxt        = '0;
    s5_nxt.base   = in_word;
    s5_nxt.hour   = hour_prod[24:20];
  end

  always_comb begin
    s6_nxt     = s5_r;
    s6_nxt.rem = 12'(s5_r.base.sec - 17'(s5_r.hour) * HOUR_SEC);
  end

  // Minutes: remainder / 60 taken as (remainder / 4) / 15.
  always_comb begin
    min_prod      = 21'(s6_r.rem[11:2]) * 21'(MIN_RECIP);
    s7_nxt        = s6_r;
    s7_nxt.minute = min_prod[19:14];
  end

  always_comb begin
    sec_left        = s7_r.rem - 12'(s7_r.minute) * MIN_SEC;
    s8_nxt.hour     = s7_r.base.hms_en ? s7_r.hour : '0;
    s8_nxt.minute   = s7_r.base.hms_en ? s7_r.minute : '0;
    s8_nxt.second   = s7_r.base.hms_en ? sec_left[5:0] : '0;
    s8_nxt.seconds  = s7_r.base.sec;
    s8_nxt.is_valid = s7_r.base.valid;
    s8_nxt.eq       = s7_r.base.eq;
    s8_nxt.lt       = s7_r.base.lt;
    s8_nxt.gt       = s7_r.base.gt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
      s7_v_r <= 1'b0;
      s8_v_r <= 1'b0;
    end else begin
      if (ready5) s5_v_r <= in_valid;
      if (ready6) s6_v_r <= s5_v_r;
      if (ready7) s7_v_r <= s6_v_r;
      if (ready8) s8_v_r <= s7_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready5 && in_valid) s5_r <= s5_nxt;
    if (ready6 && s5_v_r) s6_r <= s6_nxt;
    if (ready7 && s6_v_r) s7_r <= s7_nxt;
    if (ready8 && s7_v_r) s8_r <= s8_nxt;
  end

  assign out_valid = s8_v_r;
  assign out_word  = s8_r;

endmodule

@@ src/time_of_day_arithmetic_core.sv @@
// Top level of the time-of-day arithmetic core: stream ports and the pipeline.
//
// One operation enters as a word on the in_ stream: the operation code on
// in_tuser, times A and B and the seconds value on in_tdata. Every word gives
// exactly one result word on the out_ stream, in the order of entry.
// The core is an eight-stage pipeline with a valid bit in every stage. It
// takes one word per cycle unless a stalled output has filled every stage.
// The stage count is set by the chain of constant divisions: the day
// reduction of the seconds count, then hours, then minutes, each divide a
// reciprocal multiply with a register after it.
// When out_tready is low a finished result holds in the last stage, and the
// stages behind it keep filling until no empty stage is left; only then does
// in_tready fall. Nothing is dropped or repeated across a stall.
// Reset (rst_n low at a clock edge) empties every stage; there is no other
// state, so the core is ready in the first cycle after reset.
`include "time_of_day_arithmetic_core_defines.svh"

module time_of_day_arithmetic_core import tod_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // Bits from 0: hour_a[5:0], minute_a[11:6], second_a[17:12], hour_b[22:18],
  // minute_b[28:23], second_b[34:29], seconds_in[66:35], zero fill to 72.
  input  logic [71:0] in_tdata,
  // Bits from 0: kind[2:0].
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // Bits from 0: hour_out[4:0], minute_out[10:5], second_out[16:11],
  // seconds_out[33:17], is_valid[34], a_equal_b[35], a_less_b[36],
  // a_greater_b[37], zero fill to 40.
  output logic [39:0] out_tdata
);

  tod_in_t   in_word;
  tod_red_t  red_word;
  tod_time_t time_word;
  tod_res_t  res_word;
  logic      red_valid, red_ready, time_valid, time_ready;

  assign in_word.kind       = in_tuser;
  assign in_word.hour_a     = in_tdata[5:0];
  assign in_word.minute_a   = in_tdata[11:6];
  assign in_word.second_a   = in_tdata[17:12];
  assign in_word.hour_b     = in_tdata[22:18];
  assign in_word.minute_b   = in_tdata[28:23];
  assign in_word.second_b   = in_tdata[34:29];
  assign in_word.seconds_in = in_tdata[66:35];

  tod_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_word   (in_word),
    .out_valid (red_valid),
    .out_ready (red_ready),
    .out_word  (red_word)
  );

  tod_select u_select (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (red_valid),
    .in_ready  (red_ready),
    .in_word   (red_word),
    .out_valid (time_valid),
    .out_ready (time_ready),
    .out_word  (time_word)
  );

  tod_split u_split (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (time_valid),
    .in_ready  (time_ready),
    .in_word   (time_word),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (res_word)
  );

  assign out_tdata = {2'b00, res_word.gt, res_word.lt, res_word.eq, res_word.is_valid,
                      res_word.seconds, res_word.second, res_word.minute, res_word.hour};

  // At most one comparison flag is ever set.
  `TOD_ASSERT_IMPLY(a_flags_exclusive, out_tvalid,
                    $onehot0(out_tdata[37:35]))

  // Results are always reduced into one day.
  `TOD_ASSERT_IMPLY(a_time_in_range, out_tvalid,
                    (res_word.hour <= 5'd23) && (res_word.minute <= 6'd59) &&
                    (res_word.second <= 6'd59) && (res_word.seconds < 17'd86400))

  // A split time must agree with its seconds since midnight.
  `TOD_ASSERT_IMPLY(a_split_matches, out_tvalid && (res_word.hour != 5'd0 ||
                    res_word.minute != 6'd0 || res_word.second != 6'd0),
                    res_word.seconds == 17'(res_word.hour) * 17'd3600 +
                    17'(res_word.minute) * 17'd60 + 17'(res_word.second))

  // Input back-pressure only arises from a full pipeline behind a stalled output.
  `TOD_ASSERT_IMPLY(a_ready_only_when_full, !in_tready,
                    out_tvalid && !out_tready)

endmodule

@@ test/time_of_day_arithmetic_core_tb.sv @@
// Self-checking testbench for the time-of-day arithmetic core, with a built-in predictor.
module time_of_day_arithmetic_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tod_pkg::*;

  // Code 7 is not an operation; the core must still answer it with an all-zero word.
  localparam logic [2:0] KIND_SPARE = 3'd7;
  localparam longint unsigned SECONDS_PER_DAY = 86400;
  localparam longint unsigned SECONDS_PER_HOUR = 3600;
  localparam longint unsigned SECONDS_PER_MINUTE = 60;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata = '0;  // hour_a, minute_a, second_a, hour_b, minute_b, second_b, seconds_in
  logic [2:0]  in_tuser = '0;  // kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;      // hour, minute, second, seconds, is_valid, equal, less, greater

  tod_res_t clock_results_due[$];
  int       mismatches = 0;
  int       cycle_count = 0;
  int       send_idle_pct = 37;
  int       recv_idle_pct = 37;
  int       hold_requests = 0;
  int       hold_served = 0;
  int       stall_left = 0;

  time_of_day_arithmetic_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic tod_res_t with_clock_time(tod_res_t r, longint unsigned t);
    tod_res_t s;
    s = r;
    s.hour    = 5'(t / SECONDS_PER_HOUR);
    s.minute  = 6'((t % SECONDS_PER_HOUR) / SECONDS_PER_MINUTE);
    s.second  = 6'(t % SECONDS_PER_MINUTE);
    s.seconds = 17'(t);
    return s;
  endfunction

  function automatic tod_res_t time_of_day_result(tod_in_t op);
    longint unsigned raw_a, raw_b, red_a, red_b, n;
    tod_res_t r;
    raw_a = 64'(op.hour_a) * SECONDS_PER_HOUR + 64'(op.minute_a) * SECONDS_PER_MINUTE
            + 64'(op.second_a);
    raw_b = 64'(op.hour_b) * SECONDS_PER_HOUR + 64'(op.minute_b) * SECONDS_PER_MINUTE
            + 64'(op.second_b);
    red_a = raw_a % SECONDS_PER_DAY;
    red_b = raw_b % SECONDS_PER_DAY;
    n = 64'(op.seconds_in);
    r = '0;
    if (op.kind == KIND_SPARE) return r;
    r.is_valid = (op.hour_a <= MAX_HOUR) && (op.minute_a <= MAX_MINUTE) &&
                 (op.second_a <= MAX_SECOND);
    case (op.kind)
      KIND_TO_SEC: r.seconds = 17'(red_a);
      KIND_FROM_SEC: r = with_clock_time(r, n % SECONDS_PER_DAY);
      KIND_COMPARE: begin
        // The flags compare the times as written, before any reduction.
        r.eq = (raw_a == raw_b);
        r.lt = (raw_a < raw_b);
        r.gt = (raw_a > raw_b);
      end
      KIND_ADD: r = with_clock_time(r, (raw_a + n) % SECONDS_PER_DAY);
      KIND_SUB: r = with_clock_time(r, (red_a + SECONDS_PER_DAY - n % SECONDS_PER_DAY)
                                       % SECONDS_PER_DAY);
      KIND_DURATION: r.seconds = 17'((red_b + SECONDS_PER_DAY - red_a) % SECONDS_PER_DAY);
      default: ;
    endcase
    return r;
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_word(logic [39:0] word);
    tod_res_t want;
    if (clock_results_due.size() == 0) begin
      mismatches++;
      $display("%0t ns: unexpected result word, expected none, actual %h", $time, word);
    end else begin
      want = clock_results_due.pop_front();
      check_field("hour_out", want.hour, word[4:0]);
      check_field("minute_out", want.minute, word[10:5]);
      check_field("second_out", want.second, word[16:11]);
      check_field("seconds_out", want.seconds, word[33:17]);
      check_field("is_valid", want.is_valid, word[34]);
      check_field("a_equal_b", want.eq, word[35]);
      check_field("a_less_b", want.lt, word[36]);
      check_field("a_greater_b", want.gt, word[37]);
    end
  endtask

  // Result side: checks each accepted word, then decides the next tready. A requested
  // hold-off is counted down here so that the sender can keep pushing meanwhile.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) check_word(out_tdata);
    if (hold_served != hold_requests) begin
      hold_served++;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_op(tod_in_t op);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op.kind;
    in_tdata  <= {5'd0, op.seconds_in, op.second_b, op.minute_b, op.hour_b,
                  op.second_a, op.minute_a, op.hour_a};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    clock_results_due.push_back(time_of_day_result(op));
  endtask

  function automatic tod_in_t make_op(logic [2:0] kind, int ha, int ma, int sa,
                                      int hb, int mb, int sb, logic [31:0] n);
    tod_in_t op;
    op.kind = kind;
    op.hour_a = 6'(ha);
    op.minute_a = 6'(ma);
    op.second_a = 6'(sa);
    op.hour_b = 5'(hb);
    op.minute_b = 6'(mb);
    op.second_b = 6'(sb);
    op.seconds_in = n;
    return op;
  endfunction

  function automatic tod_in_t random_op();
    tod_in_t op;
    op.kind = 3'($urandom_range(7));
    if ($urandom_range(3) != 0) begin
      op.hour_a = 6'($urandom_range(23));
      op.minute_a = 6'($urandom_range(59));
      op.second_a = 6'($urandom_range(59));
    end else begin
      op.hour_a = 6'($urandom_range(63));
      op.minute_a = 6'($urandom_range(63));
      op.second_a = 6'($urandom_range(63));
    end
    op.hour_b = 5'($urandom_range(23));
    op.minute_b = 6'($urandom_range(59));
    op.second_b = 6'($urandom_range(59));
    // Equal times are rare by chance, so make them often for compare and duration.
    if ((op.kind == KIND_COMPARE || op.kind == KIND_DURATION) && op.hour_a <= MAX_HOUR &&
        op.minute_a <= MAX_MINUTE && op.second_a <= MAX_SECOND && $urandom_range(3) == 0) begin
      op.hour_b = 5'(op.hour_a);
      op.minute_b = op.minute_a;
      op.second_b = op.second_a;
    end
    case ($urandom_range(3))
      0: op.seconds_in = $urandom;
      1: op.seconds_in = $urandom_range(86399);
      2: op.seconds_in = 32'(86400 * $urandom_range(49710) + $urandom_range(2)) - 32'd1;
      default: op.seconds_in = $urandom_range(200000);
    endcase
    return op;
  endfunction

  task automatic test_directed();
    send_op(make_op(KIND_VALIDATE, 0, 0, 0, 0, 0, 0, 32'd0));
    send_op(make_op(KIND_VALIDATE, 23, 59, 59, 23, 59, 59, 32'd0));
    send_op(make_op(KIND_VALIDATE, 24, 0, 0, 0, 0, 0, 32'd0));
    send_op(make_op(KIND_VALIDATE, 0, 60, 0, 0, 0, 0, 32'd0));
    send_op(make_op(KIND_VALIDATE, 0, 0, 60, 0, 0, 0, 32'd0));
    send_op(make_op(KIND_VALIDATE, 63, 63, 63, 0, 0, 0, 32'hFFFF_FFFF));
    send_op(make_op(KIND_TO_SEC, 23, 59, 59, 0, 0, 0, 32'd0));
    // The largest time as written spans more than two days.
    send_op(make_op(KIND_TO_SEC, 63, 63, 63, 0, 0, 0, 32'd0));
    send_op(make_op(KIND_FROM_SEC, 0, 0, 0, 0, 0, 0, 32'd0));
    send_op(make_op(KIND_FROM_SEC, 0, 0, 0, 0, 0, 0, 32'd86399));
    send_op(make_op(KIND_FROM_SEC, 0, 0, 0, 0, 0, 0, 32'd86400));
    send_op(make_op(KIND_FROM_SEC, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_op(make_op(KIND_COMPARE, 12, 30, 15, 12, 30, 15, 32'd0));
    send_op(make_op(KIND_COMPARE, 0, 0, 0, 23, 59, 59, 32'd0));
    send_op(make_op(KIND_COMPARE, 23, 59, 59, 0, 0, 0, 32'd0));
    // Out-of-range A is later as written even though it reduces to midnight.
    send_op(make_op(KIND_COMPARE, 24, 0, 0, 23, 59, 59, 32'd0));
    send_op(make_op(KIND_ADD, 23, 59, 59, 0, 0, 0, 32'd1));
    send_op(make_op(KIND_ADD, 63, 63, 63, 0, 0, 0, 32'hFFFF_FFFF));
    send_op(make_op(KIND_SUB, 0, 0, 0, 0, 0, 0, 32'd1));
    send_op(make_op(KIND_SUB, 10, 0, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_op(make_op(KIND_SUB, 5, 5, 5, 0, 0, 0, 32'd86400));
    send_op(make_op(KIND_DURATION, 7, 8, 9, 7, 8, 9, 32'd0));
    send_op(make_op(KIND_DURATION, 23, 0, 0, 1, 0, 0, 32'd0));
    send_op(make_op(KIND_DURATION, 63, 63, 63, 0, 0, 0, 32'd0));
    send_op(make_op(KIND_SPARE, 63, 63, 63, 31, 63, 63, 32'hFFFF_FFFF));
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_op(random_op());
  endtask

  task automatic test_full_rate(int count);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (count) send_op(random_op());
    send_idle_pct = 37;
    recv_idle_pct = 37;
  endtask

  // The result side stops for a long while so the pipeline fills and in_tready drops.
  task automatic test_backpressure(int count);
    send_idle_pct = 0;
    hold_requests++;
    repeat (count) send_op(random_op());
    send_idle_pct = 37;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_mix(600);
    test_full_rate(400);
    test_backpressure(80);
    test_random_mix(600);
    in_tvalid <= 1'b0;
    while (clock_results_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && clock_results_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ time_of_day_arithmetic_core.f @@
+incdir+src
src/tod_pkg.sv
src/tod_front.sv
src/tod_select.sv
src/tod_split.sv
src/time_of_day_arithmetic_core.sv
test/time_of_day_arithmetic_core_tb.sv
